[design/prege_pkg.sv]
// ----------------------------------------------------------------------------
// prege_pkg
// shared types and constants of the pairwise repulsion energy and gradient block
// ----------------------------------------------------------------------------
package prege_pkg;

    localparam int IDX_W     = 16;
    localparam int COORD_W   = 20;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int R0_W      = 14;
    localparam int WGT_W     = 16;
    localparam int SQ_W      = 42;
    localparam int LEN_W     = 21;
    localparam int WS_W      = WGT_W + R0_W;
    localparam int PROD_W    = WS_W + R0_W;
    localparam int ETERM_W   = 26;
    localparam int ESHIFT    = 18;
    localparam int GRAD_W    = 24;
    localparam int QUO_W     = GRAD_W - 1;
    localparam int SUM_W     = 47;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 184;
    localparam int OUT_USER_W = 2;

    localparam logic [WGT_W-1:0] WEIGHT_RESET = WGT_W'(256);
    localparam logic [SQ_W-1:0]  ROOT_BIT_INIT = SQ_W'(1) << (SQ_W - 2);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(LEN_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);

    typedef struct packed {
        logic       load;
        logic       sq_step;
        logic       root_step;
        logic       prep;
        logic       emul;
        logic       gmul;
        logic       div_step;
        logic       gstore;
        logic       finish;
        logic [1:0] axis;
    } prege_cmd_t;

    typedef struct packed {
        logic out_busy;
    } prege_status_t;

endpackage

[design/pairwise_repulsion_energy_gradient_top.sv]
// ----------------------------------------------------------------------------
// pairwise_repulsion_energy_gradient_top
// harmonic repulsion energy and gradient for one atom pair per transaction
// ----------------------------------------------------------------------------
// One pair is worked on at a time. From acceptance it passes through squaring,
// one axis a cycle, the bit-per-cycle square root, the energy product, then
// three passes of one multiply, 23 restoring divide steps and a store, one per
// axis, and a move of the result to the output register. The serial divider,
// run once per axis, takes up most of that sequence. The next pair is taken in
// the cycle after the result is moved. A finished result waits in the output
// register, so the next pair may be computed while it is still waiting; the
// block takes a new pair once the previous one has been moved to that register.
// The running energy total is reported with each result and cleared after the
// result marked last.
module pairwise_repulsion_energy_gradient_top (
    input  logic         clk,
    input  logic         rst_n,
    // register port: repulsion weight in 1/256 units
    input  logic         cfg_wen,
    input  logic [15:0]  cfg_wdata,
    // input pair stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_atom, second_atom, first_x, first_y, first_z, second_x, second_y,
    // second_z, contact_distance, zero fill
    input  logic [167:0] s_tdata,
    input  logic         s_tlast,      // last_pair
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_first_atom, out_second_atom, energy_term, grad_x, grad_y, grad_z,
    // energy_total, zero fill
    output logic [183:0] m_tdata,
    output logic [1:0]   m_tuser,      // violating, coincident
    output logic         m_tlast       // total_final
);
    import prege_pkg::*;

    logic [WGT_W-1:0] weight_reg;
    prege_cmd_t       cmd;
    prege_status_t    status;

    // weight register: the user must write it only while no pair is in flight; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_wen)
        begin
            weight_reg <= cfg_wdata;
        end
    end

    prege_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    prege_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .pair_weight (weight_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef SYNTHESIS
    // one pair at a time: an accepted transaction makes the input side busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a pair is in flight");

    // a pair that does not violate carries no energy and no gradient
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[57:32] == 26'd0
            && m_tdata[129:58] == 72'd0))
        else $error("non-violating pair with non-zero terms");

    // coincident atoms give a zero gradient
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[129:58] == 72'd0))
        else $error("coincident pair with non-zero gradient");
`endif

endmodule

[design/prege_ctrl.sv]
// ----------------------------------------------------------------------------
// prege_ctrl
// sequencer stepping one pair through square, root, multiply and divide phases
// ----------------------------------------------------------------------------
module prege_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  prege_pkg::prege_status_t status,
    output prege_pkg::prege_cmd_t    cmd
);
    import prege_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_EMUL = 3'd4;
    localparam logic [2:0] ST_GMUL = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = AXIS_X;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next  = AXIS_X;
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_EMUL;
            end
            ST_EMUL:
            begin
                cmd.emul   = 1'b1;
                axis_next  = AXIS_X;
                state_next = ST_GMUL;
            end
            ST_GMUL:
            begin
                cmd.gmul   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST + CNT_W'(1))
                begin
                    // quotient complete: sign and store this axis
                    cmd.gstore = 1'b1;
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_GMUL;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/prege_dp.sv]
// ----------------------------------------------------------------------------
// prege_dp
// datapath: squared distance, bitwise root, energy and gradient multipliers, serial divider
// ----------------------------------------------------------------------------
module prege_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  prege_pkg::prege_cmd_t                 cmd,
    output prege_pkg::prege_status_t              status,
    input  logic [prege_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                  s_tlast,
    input  logic [prege_pkg::WGT_W-1:0]           pair_weight,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [prege_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [prege_pkg::OUT_USER_W-1:0]      m_tuser,
    output logic                                  m_tlast
);
    import prege_pkg::*;

    logic [IDX_W-1:0]  fa_reg, sa_reg;
    logic [DIFF_W-1:0] dabs_reg [3];
    logic [2:0]        dneg_reg;
    logic [R0_W-1:0]   r0_reg;
    logic              last_reg;
    logic [SQ_W-1:0]   v_reg, root_reg, bit_reg;
    logic [R0_W-1:0]   s_reg;
    logic [WS_W-1:0]   ws_reg;
    logic              viol_reg, coinc_reg;
    logic [ETERM_W-1:0] eterm_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  q_reg;
    logic signed [GRAD_W-1:0] grad_reg [3];
    logic [SUM_W-1:0]  sum_reg;

    logic signed [COORD_W-1:0] c1 [3];
    logic signed [COORD_W-1:0] c2 [3];
    logic signed [DIFF_W-1:0]  dsig [3];
    logic [DIFF_W-1:0]   dabs_sel;
    logic [SQ_W-1:0]     sq_prod;
    logic [SQ_W-1:0]     trial;
    logic [R0_W-1:0]     s_c;
    logic [PROD_W-1:0]   eprod, gprod;
    logic [LEN_W-1:0]    den;
    logic [LEN_W:0]      div_t;
    logic                div_ge;
    logic [GRAD_W-1:0]   mag_ext;
    logic [ETERM_W-1:0]  eterm_sel;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;
    logic                grad_on;

    assign c1[0] = s_tdata[51:32];
    assign c1[1] = s_tdata[71:52];
    assign c1[2] = s_tdata[91:72];
    assign c2[0] = s_tdata[111:92];
    assign c2[1] = s_tdata[131:112];
    assign c2[2] = s_tdata[151:132];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dsig[i] = DIFF_W'(c1[i]) - DIFF_W'(c2[i]);
        end
    end

    always_comb
    begin
        case (cmd.axis)
            AXIS_X:  dabs_sel = dabs_reg[0];
            AXIS_Y:  dabs_sel = dabs_reg[1];
            AXIS_Z:  dabs_sel = dabs_reg[2];
            default: dabs_sel = '0;
        endcase
    end

    assign sq_prod = SQ_W'(dabs_sel) * SQ_W'(dabs_sel);
    assign trial   = root_reg + bit_reg;
    assign s_c     = r0_reg - root_reg[R0_W-1:0];
    assign eprod   = PROD_W'(ws_reg) * PROD_W'(s_reg);
    assign gprod   = PROD_W'(ws_reg) * PROD_W'(dabs_sel[R0_W-1:0]);
    assign den     = {root_reg[R0_W-1:0], 7'b0};
    assign div_t   = {rem_reg, q_reg[QUO_W-1]};
    assign div_ge  = div_t >= {1'b0, den};
    assign mag_ext = {1'b0, q_reg};

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fa_reg   <= s_tdata[15:0];
            sa_reg   <= s_tdata[31:16];
            r0_reg   <= s_tdata[165:152];
            last_reg <= s_tlast;
            for (int i = 0; i < 3; i++)
            begin
                dabs_reg[i] <= dsig[i][DIFF_W-1] ? DIFF_W'(-dsig[i]) : dsig[i];
                dneg_reg[i] <= dsig[i][DIFF_W-1];
            end
            v_reg    <= '0;
            root_reg <= '0;
            bit_reg  <= ROOT_BIT_INIT;
        end
        if (cmd.sq_step)
        begin
            v_reg <= v_reg + sq_prod;
        end
        if (cmd.root_step)
        begin
            if (v_reg >= trial)
            begin
                v_reg    <= v_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.prep)
        begin
            viol_reg  <= root_reg < SQ_W'(r0_reg);
            coinc_reg <= root_reg == '0;
            s_reg     <= s_c;
            ws_reg    <= WS_W'(pair_weight) * WS_W'(s_c);
        end
        if (cmd.emul)
        begin
            eterm_reg <= eprod[PROD_W-1:ESHIFT];
        end
        if (cmd.gmul)
        begin
            rem_reg <= gprod[PROD_W-1:QUO_W];
            q_reg   <= gprod[QUO_W-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? LEN_W'(div_t - {1'b0, den}) : div_t[LEN_W-1:0];
            q_reg   <= {q_reg[QUO_W-2:0], div_ge};
        end
        if (cmd.gstore)
        begin
            // gradient takes the sign opposite to the coordinate difference
            case (cmd.axis)
                AXIS_X:  grad_reg[0] <= dneg_reg[0] ? mag_ext : -mag_ext;
                AXIS_Y:  grad_reg[1] <= dneg_reg[1] ? mag_ext : -mag_ext;
                AXIS_Z:  grad_reg[2] <= dneg_reg[2] ? mag_ext : -mag_ext;
                default: ;
            endcase
        end
    end

    assign grad_on   = viol_reg && !coinc_reg;
    assign eterm_sel = viol_reg ? eterm_reg : '0;
    assign sum_add   = {1'b0, sum_reg} + (SUM_W+1)'(eterm_sel);
    assign sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            m_tvalid <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                sum_reg  <= last_reg ? '0 : sum_sat;
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_tdata <= {7'b0, sum_sat,
                        grad_on ? grad_reg[2] : GRAD_W'(0),
                        grad_on ? grad_reg[1] : GRAD_W'(0),
                        grad_on ? grad_reg[0] : GRAD_W'(0),
                        eterm_sel, sa_reg, fa_reg};
            m_tuser <= {coinc_reg, viol_reg};
            m_tlast <= last_reg;
        end
    end

    assign status.out_busy = m_tvalid && !m_tready;

endmodule
